// ===== sv/mecanum_wheel_mixer_unit_defines.svh =====
// Assertion macros for the mecanum wheel mixer checker.
// No dependencies; included by the checker file.
`ifndef MECANUM_WHEEL_MIXER_UNIT_DEFINES_SVH
`define MECANUM_WHEEL_MIXER_UNIT_DEFINES_SVH

// Check that a condition implies a property in the same cycle
`define MWM_ASSERT_NOW(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Check that a condition implies a property in the next cycle
`define MWM_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== sv/mwm_pkg.sv =====
// Shared types and constants for the mecanum wheel mixer.
// No dependencies; imported by every module of the block.
package mwm_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WHEELS        = 4;
    localparam int IN_W          = 32;
    localparam int OUT_W         = 32;
    localparam int RAD_W         = 20;
    localparam int LIM_W         = 31;
    localparam int REV_W         = 4;
    localparam int LW_W          = 54;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 31;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HLEN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HWID    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE = 3'd4;

    localparam logic [RAD_W-1:0] RADIUS_RST = 20'd3277;
    localparam logic [RAD_W-1:0] HLEN_RST   = 20'd6554;
    localparam logic [RAD_W-1:0] HWID_RST   = 20'd6554;
    localparam logic [LIM_W-1:0] LIMIT_RST  = 31'd6553600;
    localparam logic [REV_W-1:0] REV_RST    = 4'd0;

    typedef struct packed {
        logic [RAD_W-1:0] radius;
        logic [LIM_W-1:0] limit;
        logic [REV_W-1:0] rev;
        logic             valid;
    } mwm_cfg_t;

endpackage

// ===== sv/mecanum_wheel_mixer_unit.sv =====
// Mecanum wheel mixer: body velocity command in, four wheel speeds out.
// Usage:
//   Slave stream s_* carries one command: tdata = vel_forward, vel_side, yaw_rate.
//   Master stream m_* returns one result per command: tdata = four wheel speeds
//   (FL, FR, RL, RR), tuser = ok. A transfer happens when tvalid and tready are high.
//   Configuration: cfg_we with cfg_addr 0..4 (radius, half length, half width,
//   speed limit, reverse mask); write only while no command is in flight.
// Operation:
//   The front registers the command and forms the exact wheel magnitudes from the
//   registered values, then a two-entry queue hands them to the back. The back divides by
//   the radius one quotient bit per cycle (MAG_W bits, 55 at 16 fraction bits)
//   and, when the limit is exceeded, multiplies in two steps and divides again
//   one bit per cycle (MAG_W+31 bits). The back takes a new command only once
//   the last result is in the output register, so the restoring divider sets
//   the rate.
//   An invalid configuration gives zero speeds with ok low and skips the divider.
// Reset: clears pipeline, queue and output valid; registers return to defaults.
// Stall: a held result stays in the output register; the back then waits and
//   the queue and front keep taking commands until they fill.
module mecanum_wheel_mixer_unit
    import mwm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [3*IN_W-1:0]     s_tdata,   // vel_forward, vel_side, yaw_rate
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [4*OUT_W-1:0]    m_tdata,   // front_left, front_right, rear_left, rear_right
    output logic                  m_tuser    // ok
);

    localparam int MAG_W = (((IN_W + 1 + FRAC_BITS) > LW_W) ? (IN_W + 1 + FRAC_BITS) : LW_W) + 1;
    localparam int QW    = 4 * MAG_W + 5;

    mwm_cfg_t        cfg;
    logic            push;
    logic            full;
    logic            pop;
    logic            nonempty;
    logic [QW-1:0]   push_data;
    logic [QW-1:0]   pop_data;

    mwm_front #(.FRAC_BITS(FRAC_BITS), .MAG_W(MAG_W)) u_front (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .cfg(cfg), .full(full), .push(push), .push_data(push_data)
    );

    mwm_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(push), .push_data(push_data), .full(full),
        .pop(pop), .nonempty(nonempty), .pop_data(pop_data)
    );

    mwm_back #(.MAG_W(MAG_W)) u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg),
        .nonempty(nonempty), .pop_data(pop_data), .pop(pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

endmodule

// ===== sv/mwm_front.sv =====
// Front part: configuration registers, request intake, wheel sums and magnitudes.
// Depends on mwm_pkg.
module mwm_front
    import mwm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int MAG_W     = 55
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_addr,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [3*IN_W-1:0]       s_tdata,
    output mwm_cfg_t                cfg,
    input  logic                    full,
    output logic                    push,
    output logic [4*MAG_W+4:0]      push_data
);

    logic [RAD_W-1:0] radius_reg;
    logic [RAD_W-1:0] hlen_reg;
    logic [RAD_W-1:0] hwid_reg;
    logic [LIM_W-1:0] limit_reg;
    logic [REV_W-1:0] rev_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RST;
            hlen_reg   <= HLEN_RST;
            hwid_reg   <= HWID_RST;
            limit_reg  <= LIMIT_RST;
            rev_reg    <= REV_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_RADIUS:  radius_reg <= cfg_wdata[RAD_W-1:0];
                CFG_HLEN:    hlen_reg   <= cfg_wdata[RAD_W-1:0];
                CFG_HWID:    hwid_reg   <= cfg_wdata[RAD_W-1:0];
                CFG_LIMIT:   limit_reg  <= cfg_wdata[LIM_W-1:0];
                CFG_REVERSE: rev_reg    <= cfg_wdata[REV_W-1:0];
                default:     ;
            endcase
        end
    end

    assign cfg.radius = radius_reg;
    assign cfg.limit  = limit_reg;
    assign cfg.rev    = rev_reg;
    assign cfg.valid  = (radius_reg != '0) && (limit_reg != '0);

    // Stage one: capture request and lever times yaw rate
    logic                    s1_valid_reg;
    logic signed [IN_W-1:0]  vf_reg;
    logic signed [IN_W-1:0]  vs_reg;
    logic signed [LW_W-1:0]  lw_reg;
    logic [RAD_W:0]          lever;
    logic signed [LW_W-1:0]  lw_next;

    assign lever    = {1'b0, hlen_reg} + {1'b0, hwid_reg};
    assign lw_next  = $signed({1'b0, lever}) * $signed(s_tdata[3*IN_W-1:2*IN_W]);
    assign push     = s1_valid_reg && !full;
    assign s_tready = !s1_valid_reg || !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_tready)
            s1_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            vf_reg <= s_tdata[IN_W-1:0];
            vs_reg <= s_tdata[2*IN_W-1:IN_W];
            lw_reg <= lw_next;
        end
    end

    // Stage two: exact wheel sums, then sign and magnitude
    logic signed [IN_W:0]    dif;
    logic signed [IN_W:0]    add;
    logic signed [MAG_W-1:0] dif_w;
    logic signed [MAG_W-1:0] add_w;
    logic signed [MAG_W-1:0] lw_w;
    logic signed [MAG_W-1:0] sum [WHEELS];
    logic [MAG_W-1:0]        mag [WHEELS];
    logic [WHEELS-1:0]       neg;

    always_comb
    begin
        dif    = {vf_reg[IN_W-1], vf_reg} - {vs_reg[IN_W-1], vs_reg};
        add    = {vf_reg[IN_W-1], vf_reg} + {vs_reg[IN_W-1], vs_reg};
        dif_w  = MAG_W'(dif) <<< FRAC_BITS;
        add_w  = MAG_W'(add) <<< FRAC_BITS;
        lw_w   = MAG_W'(lw_reg);
        sum[0] = dif_w - lw_w;
        sum[1] = add_w + lw_w;
        sum[2] = add_w - lw_w;
        sum[3] = dif_w + lw_w;
        for (int k = 0; k < WHEELS; k++)
        begin
            neg[k] = sum[k][MAG_W-1];
            mag[k] = neg[k] ? MAG_W'(-sum[k]) : MAG_W'(sum[k]);
        end
    end

    assign push_data = {cfg.valid, neg, mag[3], mag[2], mag[1], mag[0]};

endmodule

// ===== sv/mwm_queue.sv =====
// Short queue between front and back parts of the mixer.
// Depends on mwm_pkg.
module mwm_queue
    import mwm_pkg::*;
#(
    parameter int WIDTH = 225,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             nonempty,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign pop_data = mem[rd_ptr_reg];

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== sv/mwm_back.sv =====
// Back part: divide by radius, limit scaling, reverse and output register.
// Depends on mwm_pkg.
module mwm_back
    import mwm_pkg::*;
#(
    parameter int MAG_W = 55
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  mwm_cfg_t               cfg,
    input  logic                   nonempty,
    input  logic [4*MAG_W+4:0]     pop_data,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [4*OUT_W-1:0]     m_tdata,
    output logic                   m_tuser
);

    localparam int PROD_W = MAG_W + LIM_W;
    localparam int CNT_W  = $clog2(PROD_W + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DIV1   = 3'd1;
    localparam logic [2:0] ST_MAX1   = 3'd2;
    localparam logic [2:0] ST_MAX2   = 3'd3;
    localparam logic [2:0] ST_MUL_LO = 3'd4;
    localparam logic [2:0] ST_MUL_HI = 3'd5;
    localparam logic [2:0] ST_DIV2   = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [2:0]          state_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [MAG_W-1:0]    mag_reg [WHEELS];
    logic [PROD_W-1:0]   num_reg [WHEELS];
    logic [MAG_W-1:0]    rem_reg [WHEELS];
    logic [WHEELS-1:0]   neg_reg;
    logic                ok_reg;
    logic [MAG_W-1:0]    m01_reg;
    logic [MAG_W-1:0]    m23_reg;
    logic [MAG_W-1:0]    largest_reg;
    logic                out_valid_reg;
    logic [4*OUT_W-1:0]  out_data_reg;
    logic                out_ok_reg;

    // One restoring divide step per lane, one multiplier per lane
    logic [MAG_W-1:0]    divisor;
    logic [MAG_W:0]      trial   [WHEELS];
    logic                ge      [WHEELS];
    logic [MAG_W-1:0]    rem_new [WHEELS];
    logic [PROD_W-1:0]   num_new [WHEELS];
    logic [31:0]         mul_op  [WHEELS];
    logic [63+LIM_W-32:0] mul_p  [WHEELS];
    logic [MAG_W-1:0]    max01;
    logic [MAG_W-1:0]    max23;
    logic [MAG_W-1:0]    max_all;
    logic                out_load;
    logic [4*OUT_W-1:0]  out_next;

    assign divisor = (state_reg == ST_DIV1) ? MAG_W'(cfg.radius) : largest_reg;

    always_comb
    begin
        for (int k = 0; k < WHEELS; k++)
        begin
            trial[k]   = {rem_reg[k], num_reg[k][PROD_W-1]};
            ge[k]      = trial[k] >= {1'b0, divisor};
            rem_new[k] = ge[k] ? MAG_W'(trial[k] - {1'b0, divisor}) : MAG_W'(trial[k]);
            num_new[k] = {num_reg[k][PROD_W-2:0], ge[k]};
            mul_op[k]  = (state_reg == ST_MUL_LO) ? mag_reg[k][31:0]
                                                  : 32'(mag_reg[k][MAG_W-1:32]);
            mul_p[k]   = mul_op[k] * cfg.limit;
        end
        max01   = (num_reg[0][MAG_W-1:0] > num_reg[1][MAG_W-1:0]) ?
                  num_reg[0][MAG_W-1:0] : num_reg[1][MAG_W-1:0];
        max23   = (num_reg[2][MAG_W-1:0] > num_reg[3][MAG_W-1:0]) ?
                  num_reg[2][MAG_W-1:0] : num_reg[3][MAG_W-1:0];
        max_all = (m01_reg > m23_reg) ? m01_reg : m23_reg;
    end

    // Sign, reverse and zero on invalid configuration
    always_comb
    begin
        for (int k = 0; k < WHEELS; k++)
        begin
            if (!ok_reg)
                out_next[k*OUT_W +: OUT_W] = '0;
            else if (neg_reg[k] ^ cfg.rev[k])
                out_next[k*OUT_W +: OUT_W] = -mag_reg[k][OUT_W-1:0];
            else
                out_next[k*OUT_W +: OUT_W] = mag_reg[k][OUT_W-1:0];
        end
    end

    assign pop      = (state_reg == ST_IDLE) && nonempty;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (nonempty)
                    begin
                        cnt_reg   <= CNT_W'(MAG_W);
                        state_reg <= pop_data[4*MAG_W+4] ? ST_DIV1 : ST_DONE;
                    end
                end
                ST_DIV1:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                        state_reg <= ST_MAX1;
                end
                ST_MAX1:   state_reg <= ST_MAX2;
                ST_MAX2:   state_reg <= (max_all > MAG_W'(cfg.limit)) ? ST_MUL_LO : ST_DONE;
                ST_MUL_LO: state_reg <= ST_MUL_HI;
                ST_MUL_HI:
                begin
                    cnt_reg   <= CNT_W'(PROD_W);
                    state_reg <= ST_DIV2;
                end
                ST_DIV2:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_load)
                        state_reg <= ST_IDLE;
                end
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (nonempty)
                begin
                    neg_reg <= pop_data[4*MAG_W +: WHEELS];
                    ok_reg  <= pop_data[4*MAG_W+4];
                    for (int k = 0; k < WHEELS; k++)
                    begin
                        num_reg[k] <= {pop_data[k*MAG_W +: MAG_W], {LIM_W{1'b0}}};
                        rem_reg[k] <= '0;
                    end
                end
            end
            ST_DIV1, ST_DIV2:
            begin
                for (int k = 0; k < WHEELS; k++)
                begin
                    num_reg[k] <= num_new[k];
                    rem_reg[k] <= rem_new[k];
                    if (cnt_reg == CNT_W'(1))
                        mag_reg[k] <= num_new[k][MAG_W-1:0];
                end
            end
            ST_MAX1:
            begin
                m01_reg <= max01;
                m23_reg <= max23;
            end
            ST_MAX2:
                largest_reg <= max_all;
            ST_MUL_LO:
            begin
                for (int k = 0; k < WHEELS; k++)
                    num_reg[k] <= PROD_W'(mul_p[k]);
            end
            ST_MUL_HI:
            begin
                for (int k = 0; k < WHEELS; k++)
                begin
                    num_reg[k] <= num_reg[k] + (PROD_W'(mul_p[k]) << 32);
                    rem_reg[k] <= '0;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_data_reg <= out_next;
                    out_ok_reg   <= ok_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_ok_reg;

endmodule

// ===== sv/mwm_checker.sv =====
// Port-level checks for the mecanum wheel mixer, bound to the top level.
// Depends on mwm_pkg and mecanum_wheel_mixer_unit_defines.svh.
`include "mecanum_wheel_mixer_unit_defines.svh"

module mwm_checker
    import mwm_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [4*OUT_W-1:0] m_tdata,
    input logic               m_tuser
);

    // Hold a stalled result
    `MWM_ASSERT_NEXT(a_hold_valid, clk, rst_n, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

    // Invalid configuration gives zero speeds
    `MWM_ASSERT_NOW(a_zero_on_fail, clk, rst_n, m_tvalid && !m_tuser, m_tdata == '0, "nonzero speed with ok low")

    // No result right out of reset
    `MWM_ASSERT_NOW(a_reset_quiet, clk, rst_n, !$past(rst_n), !m_tvalid, "result valid after reset")

endmodule

bind mecanum_wheel_mixer_unit mwm_checker u_mwm_checker (.*);
